// ===== rtl/core/tct_pkg.sv =====
// Package for the compacting tagged entry table.
// Sizes, operation and status codes, controller states, and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package tct_pkg;

    localparam int DEPTH        = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int MODE_W   = 2;
    localparam int TAG_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes on the mode field.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TAKE   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_END,
        ST_TAKE_CAP,
        ST_TAKE_NEXT,
        ST_TAKE_SHIFT,
        ST_TAKE_DONE
    } state_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_SLOT,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_NEXT,
        RD_SLOT
    } rd_sel_t;

    typedef enum logic [2:0] {
        OUT_INS_OK,
        OUT_FULL,
        OUT_BAD_SLOT,
        OUT_MATCH,
        OUT_SCAN_END,
        OUT_TAKE
    } out_kind_t;

    typedef struct packed {
        logic      latch;
        logic      mem_rd;
        rd_sel_t   rd_sel;
        logic      shift_wr;
        logic      ins_wr;
        idx_op_t   idx_op;
        logic      pend_clear;
        logic      pend_set;
        logic      take_cap;
        logic      count_dec;
        logic      out_load;
        out_kind_t out_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              slot_bad;
        logic              count_zero;
        logic              tag_match;
        logic              idx_at_end;
        logic              out_free;
        logic              have_pend;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tct_ctrl.sv =====
// Controller state machine for the compacting tagged entry table.
// Depends on tct_pkg; drives tct_datapath through ctrl_cmd_t.
`default_nettype none

module tct_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  tct_pkg::dp_stat_t   stat,
    output tct_pkg::ctrl_cmd_t  cmd
);

    tct_pkg::state_t state_reg;
    tct_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tct_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        cmd            = '0;
        cmd.rd_sel     = tct_pkg::RD_IDX;
        cmd.idx_op     = tct_pkg::IDX_HOLD;
        cmd.out_kind   = tct_pkg::OUT_INS_OK;

        unique case (state_reg)
            tct_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = tct_pkg::ST_DECODE;
                end
            end

            tct_pkg::ST_DECODE:
            begin
                if (stat.mode == tct_pkg::MODE_INSERT)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        if (stat.full)
                        begin
                            cmd.out_kind = tct_pkg::OUT_FULL;
                        end
                        else
                        begin
                            cmd.ins_wr   = 1'b1;
                            cmd.out_kind = tct_pkg::OUT_INS_OK;
                        end
                        state_next = tct_pkg::ST_IDLE;
                    end
                end
                else if (stat.mode == tct_pkg::MODE_SCAN)
                begin
                    cmd.idx_op     = tct_pkg::IDX_CLEAR;
                    cmd.pend_clear = 1'b1;
                    state_next     = stat.count_zero ? tct_pkg::ST_SCAN_END
                                                     : tct_pkg::ST_SCAN_RD;
                end
                else if (stat.mode == tct_pkg::MODE_TAKE)
                begin
                    if (stat.slot_bad)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = tct_pkg::OUT_BAD_SLOT;
                            state_next   = tct_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.mem_rd = 1'b1;
                        cmd.rd_sel = tct_pkg::RD_SLOT;
                        cmd.idx_op = tct_pkg::IDX_SLOT;
                        state_next = tct_pkg::ST_TAKE_CAP;
                    end
                end
                else
                begin
                    // unused mode: dropped without a result
                    state_next = tct_pkg::ST_IDLE;
                end
            end

            tct_pkg::ST_SCAN_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = tct_pkg::RD_IDX;
                state_next = tct_pkg::ST_SCAN_CMP;
            end

            tct_pkg::ST_SCAN_CMP:
            begin
                // a new match pushes the held one out, so wait for room
                if (!(stat.tag_match && stat.have_pend && !stat.out_free))
                begin
                    if (stat.tag_match)
                    begin
                        cmd.pend_set = 1'b1;
                        if (stat.have_pend)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = tct_pkg::OUT_MATCH;
                        end
                    end
                    if (stat.idx_at_end)
                    begin
                        state_next = tct_pkg::ST_SCAN_END;
                    end
                    else
                    begin
                        cmd.idx_op = tct_pkg::IDX_INC;
                        state_next = tct_pkg::ST_SCAN_RD;
                    end
                end
            end

            tct_pkg::ST_SCAN_END:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = tct_pkg::OUT_SCAN_END;
                    state_next   = tct_pkg::ST_IDLE;
                end
            end

            tct_pkg::ST_TAKE_CAP:
            begin
                cmd.take_cap = 1'b1;
                state_next   = tct_pkg::ST_TAKE_NEXT;
            end

            tct_pkg::ST_TAKE_NEXT:
            begin
                if (stat.idx_at_end)
                begin
                    state_next = tct_pkg::ST_TAKE_DONE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = tct_pkg::RD_IDX_NEXT;
                    state_next = tct_pkg::ST_TAKE_SHIFT;
                end
            end

            tct_pkg::ST_TAKE_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_op   = tct_pkg::IDX_INC;
                state_next   = tct_pkg::ST_TAKE_NEXT;
            end

            tct_pkg::ST_TAKE_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.count_dec = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = tct_pkg::OUT_TAKE;
                    state_next    = tct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tct_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/tct_datapath.sv =====
// Datapath for the compacting tagged entry table: entry memory, count,
// capacity register, walk index, held match and result register.
// Depends on tct_pkg; steered by tct_ctrl.
`default_nettype none

module tct_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tct_pkg::CNT_W-1:0]      cfg_wr_data,
    input  wire logic [tct_pkg::MODE_W-1:0]     mode,
    input  wire logic [tct_pkg::TAG_W-1:0]      tag,
    input  wire logic [tct_pkg::WORD_W-1:0]     payload,
    input  wire logic [tct_pkg::IDX_W-1:0]      slot,
    input  tct_pkg::ctrl_cmd_t                  cmd,
    output tct_pkg::dp_stat_t                   stat,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [tct_pkg::STATUS_W-1:0]        status,
    output logic [tct_pkg::IDX_W-1:0]           index_out,
    output logic [tct_pkg::TAG_W-1:0]           tag_out,
    output logic [tct_pkg::WORD_W-1:0]          payload_out,
    output logic [tct_pkg::CNT_W-1:0]           entries_in_use,
    output logic                                last
);

    localparam logic [tct_pkg::CNT_W-1:0] DEPTH_CNT = tct_pkg::CNT_W'(tct_pkg::DEPTH);

    // entry storage: one write port, one registered read port
    logic [tct_pkg::TAG_W-1:0]        tag_mem [tct_pkg::DEPTH];
    logic [tct_pkg::PAYLOAD_BITS-1:0] pay_mem [tct_pkg::DEPTH];
    logic [tct_pkg::TAG_W-1:0]        rd_tag_reg;
    logic [tct_pkg::PAYLOAD_BITS-1:0] rd_pay_reg;
    logic [tct_pkg::IDX_W-1:0]        rd_addr;
    logic [tct_pkg::IDX_W-1:0]        wr_addr;
    logic [tct_pkg::TAG_W-1:0]        wr_tag;
    logic [tct_pkg::PAYLOAD_BITS-1:0] wr_pay;
    logic                             wr_en;

    logic [tct_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [tct_pkg::CNT_W-1:0]        cap_reg;
    logic [tct_pkg::CNT_W-1:0]        cap_eff;
    logic [tct_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [tct_pkg::IDX_W-1:0]        idx_plus1;

    // latched request
    logic [tct_pkg::MODE_W-1:0]       q_mode_reg;
    logic [tct_pkg::TAG_W-1:0]        q_tag_reg;
    logic [tct_pkg::PAYLOAD_BITS-1:0] q_pay_reg;
    logic [tct_pkg::IDX_W-1:0]        q_slot_reg;

    logic                             pend_reg;
    logic [tct_pkg::IDX_W-1:0]        pend_idx_reg;
    logic [tct_pkg::TAG_W-1:0]        take_tag_reg;
    logic [tct_pkg::PAYLOAD_BITS-1:0] take_pay_reg;

    logic                             out_valid_reg;
    logic [tct_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [tct_pkg::IDX_W-1:0]        index_reg, index_next;
    logic [tct_pkg::TAG_W-1:0]        tag_out_reg, tag_out_next;
    logic [tct_pkg::WORD_W-1:0]       pay_out_reg, pay_out_next;
    logic [tct_pkg::CNT_W-1:0]        entries_reg;
    logic                             last_reg, last_next;

    assign idx_plus1 = idx_reg + 1'b1;
    assign cap_eff   = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;

    always_comb
    begin
        unique case (cmd.rd_sel)
            tct_pkg::RD_IDX:      rd_addr = idx_reg;
            tct_pkg::RD_IDX_NEXT: rd_addr = idx_plus1;
            tct_pkg::RD_SLOT:     rd_addr = q_slot_reg;
            default:              rd_addr = idx_reg;
        endcase
    end

    assign wr_en   = cmd.ins_wr | cmd.shift_wr;
    assign wr_addr = cmd.ins_wr ? count_reg[tct_pkg::IDX_W-1:0] : idx_reg;
    assign wr_tag  = cmd.ins_wr ? q_tag_reg : rd_tag_reg;
    assign wr_pay  = cmd.ins_wr ? q_pay_reg : rd_pay_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (cmd.mem_rd)
        begin
            rd_tag_reg <= tag_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_wr)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.idx_op)
            tct_pkg::IDX_HOLD:  idx_next = idx_reg;
            tct_pkg::IDX_CLEAR: idx_next = '0;
            tct_pkg::IDX_SLOT:  idx_next = q_slot_reg;
            tct_pkg::IDX_INC:   idx_next = idx_plus1;
            default:            idx_next = idx_reg;
        endcase
    end

    // result formatting
    always_comb
    begin
        status_next  = tct_pkg::STATUS_OK;
        index_next   = '0;
        tag_out_next = '0;
        pay_out_next = '0;
        last_next    = 1'b1;
        unique case (cmd.out_kind)
            tct_pkg::OUT_INS_OK:
            begin
                status_next = tct_pkg::STATUS_OK;
            end
            tct_pkg::OUT_FULL:
            begin
                status_next = tct_pkg::STATUS_FULL;
            end
            tct_pkg::OUT_BAD_SLOT:
            begin
                status_next = tct_pkg::STATUS_BAD_SLOT;
                index_next  = q_slot_reg;
            end
            tct_pkg::OUT_MATCH:
            begin
                index_next = pend_idx_reg;
                last_next  = 1'b0;
            end
            tct_pkg::OUT_SCAN_END:
            begin
                status_next = pend_reg ? tct_pkg::STATUS_OK : tct_pkg::STATUS_NO_MATCH;
                index_next  = pend_reg ? pend_idx_reg : '0;
            end
            tct_pkg::OUT_TAKE:
            begin
                index_next   = q_slot_reg;
                tag_out_next = take_tag_reg;
                pay_out_next = tct_pkg::WORD_W'(take_pay_reg);
            end
            default:
            begin
                status_next = tct_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= DEPTH_CNT;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.pend_clear)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.pend_set)
            begin
                pend_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            q_mode_reg <= mode;
            q_tag_reg  <= tag;
            q_pay_reg  <= tct_pkg::PAYLOAD_BITS'(payload);
            q_slot_reg <= slot;
        end
        if (cmd.pend_set)
        begin
            pend_idx_reg <= idx_reg;
        end
        if (cmd.take_cap)
        begin
            take_tag_reg <= rd_tag_reg;
            take_pay_reg <= rd_pay_reg;
        end
        if (cmd.out_load)
        begin
            status_reg  <= status_next;
            index_reg   <= index_next;
            tag_out_reg <= tag_out_next;
            pay_out_reg <= pay_out_next;
            entries_reg <= count_next;
            last_reg    <= last_next;
        end
    end

    assign stat.mode       = q_mode_reg;
    assign stat.full       = (count_reg >= cap_eff);
    assign stat.slot_bad   = ({1'b0, q_slot_reg} >= count_reg);
    assign stat.count_zero = (count_reg == '0);
    assign stat.tag_match  = (rd_tag_reg == q_tag_reg);
    assign stat.idx_at_end = ({1'b0, idx_reg} + 1'b1 >= count_reg);
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.have_pend  = pend_reg;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign index_out      = index_reg;
    assign tag_out        = tag_out_reg;
    assign payload_out    = pay_out_reg;
    assign entries_in_use = entries_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tagged_compacting_table_unit.sv =====
// Top level of the compacting tagged entry table.
// Depends on tct_pkg, tct_ctrl and tct_datapath.
//
// A packed table of up to 32 entries (8-bit tag, 32-bit payload) kept in
// insertion order. One request is worked at a time: the input stalls from
// the cycle after a request is taken until its last result is loaded into
// the output register, which then holds it independently of the next
// request. Insert (mode 0) reports full when the count has reached the
// capacity register (values above 32 act as 32, zero means always full).
// Scan (mode 1) returns one result per tag match in order with last on the
// final one, or a single no-match result. Take (mode 2) returns the entry
// and closes the gap, or flags a slot at or beyond the count. Scan and take
// step through the entries over the registered read of the entry memory:
// an entry is read in one cycle and compared or written back in the next.
// A stalled output holds the block only while a new result finds the
// output register still full. Mode 3 is dropped with no result. The
// capacity register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, as the block itself does
// not enforce this.
`default_nettype none

module tagged_compacting_table_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_wr_en,
    input  wire logic [tct_pkg::CNT_W-1:0]      cfg_wr_data,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tct_pkg::MODE_W-1:0]     mode,
    input  wire logic [tct_pkg::TAG_W-1:0]      tag,
    input  wire logic [tct_pkg::WORD_W-1:0]     payload,
    input  wire logic [tct_pkg::IDX_W-1:0]      slot,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [tct_pkg::STATUS_W-1:0]        status,
    output logic [tct_pkg::IDX_W-1:0]           index_out,
    output logic [tct_pkg::TAG_W-1:0]           tag_out,
    output logic [tct_pkg::WORD_W-1:0]          payload_out,
    output logic [tct_pkg::CNT_W-1:0]           entries_in_use,
    output logic                                last
);

    // command and status bundles between sequencer and datapath
    tct_pkg::ctrl_cmd_t cmd;
    tct_pkg::dp_stat_t  stat;

    tct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // the request fields are latched into the datapath on acceptance
    tct_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mode           (mode),
        .tag            (tag),
        .payload        (payload),
        .slot           (slot),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .index_out      (index_out),
        .tag_out        (tag_out),
        .payload_out    (payload_out),
        .entries_in_use (entries_in_use),
        .last           (last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tct_checker.sv =====
// Port-level checks for the compacting tagged entry table, bound to the
// top level. Depends on tct_pkg and tagged_compacting_table_unit.
`default_nettype none

module tct_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [tct_pkg::STATUS_W-1:0]   status,
    input wire logic [tct_pkg::IDX_W-1:0]      index_out,
    input wire logic [tct_pkg::TAG_W-1:0]      tag_out,
    input wire logic [tct_pkg::WORD_W-1:0]     payload_out,
    input wire logic [tct_pkg::CNT_W-1:0]      entries_in_use,
    input wire logic                           last
);

    // one request at a time: the input closes right after a request
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(index_out) && $stable(last))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_in_use <= tct_pkg::CNT_W'(tct_pkg::DEPTH))
        else $error("entry count beyond depth");

    // full, bad slot and no match are always single, empty results
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tct_pkg::STATUS_FULL
            || status == tct_pkg::STATUS_BAD_SLOT
            || status == tct_pkg::STATUS_NO_MATCH)
        |-> last && tag_out == '0 && payload_out == '0)
        else $error("error result not single or not empty");

endmodule

bind tagged_compacting_table_unit tct_checker u_tct_checker (.*);

`default_nettype wire

// ===== verif/tagged_compacting_table_unit_test.sv =====
// Self-checking testbench for the compacting tagged entry table.
// Needs tct_pkg and tagged_compacting_table_unit. A directed table and then
// random request phases are checked against a behavioral shadow of the table.
module tagged_compacting_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tct_pkg::*;

    // The package names modes 0..2 only; mode 3 is dropped by the block.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 350;
    localparam int SETTLE_CYCLES   = 8;     // covers a dropped request still in flight
    localparam int TAIL_CYCLES     = 20;
    localparam int CYCLE_LIMIT     = 600_000;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [TAG_W-1:0]   tag;
        logic [WORD_W-1:0]  payload;
        logic [IDX_W-1:0]   slot;
    } table_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [TAG_W-1:0]    tag;
        logic [WORD_W-1:0]   word;
        logic [CNT_W-1:0]    count;
        logic                last;
    } table_result_t;

    typedef enum {ROW_PREDICTED, ROW_TYPED, ROW_CAPACITY} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        table_req_t          req;
        table_result_t       want;
        logic [CNT_W-1:0]    capacity;
    } directed_row_t;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CNT_W-1:0]     cfg_wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode;
    logic [TAG_W-1:0]     tag;
    logic [WORD_W-1:0]    payload;
    logic [IDX_W-1:0]     slot;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     index_out;
    logic [TAG_W-1:0]     tag_out;
    logic [WORD_W-1:0]    payload_out;
    logic [CNT_W-1:0]     entries_in_use;
    logic                 last;

    // Shadow copy of the table contents and the capacity register
    logic [TAG_W-1:0]     shadow_tags [DEPTH];
    logic [WORD_W-1:0]    shadow_words [DEPTH];
    logic [CNT_W-1:0]     shadow_count;
    logic [CNT_W-1:0]     shadow_capacity;

    table_result_t        step_results[$];     // results of the request just taken
    table_result_t        pending_results[$];  // results still owed by the block
    directed_row_t        directed_rows[$];

    int failures        = 0;
    int results_checked = 0;
    int cycles          = 0;
    int burst_left      = 0;
    int capacity_writes = 0;
    int longest_scan    = 0;
    int random_sent     = 0;
    int mode_seen[4]    = '{0, 0, 0, 0};
    int status_seen[4]  = '{0, 0, 0, 0};
    int capacity_plan[8] = '{32, 1, 63, 0, 33, 8, 31, 20};

    tagged_compacting_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .tag            (tag),
        .payload        (payload),
        .slot           (slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .index_out      (index_out),
        .tag_out        (tag_out),
        .payload_out    (payload_out),
        .entries_in_use (entries_in_use),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Shadow table: work out what one accepted request returns
    //------------------------------------------------------------------
    function automatic table_result_t make_result(logic [STATUS_W-1:0] st,
                                                  logic [IDX_W-1:0] idx,
                                                  logic [TAG_W-1:0] tg,
                                                  logic [WORD_W-1:0] w,
                                                  logic [CNT_W-1:0] cnt,
                                                  logic fin);
        table_result_t res;
        res.status = st;
        res.index  = idx;
        res.tag    = tg;
        res.word   = w;
        res.count  = cnt;
        res.last   = fin;
        return res;
    endfunction

    function automatic void predict_table_op(input table_req_t r);
        int                eff_cap;
        int                hits;
        int                seen;
        logic [TAG_W-1:0]  taken_tag;
        logic [WORD_W-1:0] taken_word;
        step_results.delete();
        // capacity above the table depth acts as the depth
        eff_cap = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        hits = 0;
        seen = 0;
        case (r.mode)
            MODE_INSERT:
            begin
                if (shadow_count >= eff_cap)
                    step_results.push_back(make_result(STATUS_FULL, '0, '0, '0,
                                                       shadow_count, 1'b1));
                else
                begin
                    shadow_tags[shadow_count]  = r.tag;
                    shadow_words[shadow_count] = r.payload;
                    shadow_count = shadow_count + 1'b1;
                    step_results.push_back(make_result(STATUS_OK, '0, '0, '0,
                                                       shadow_count, 1'b1));
                end
            end
            MODE_SCAN:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_tags[i] == r.tag)
                        hits++;
                if (hits == 0)
                    step_results.push_back(make_result(STATUS_NO_MATCH, '0, '0, '0,
                                                       shadow_count, 1'b1));
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_tags[i] == r.tag)
                    begin
                        seen++;
                        step_results.push_back(make_result(STATUS_OK, IDX_W'(i), '0, '0,
                                                           shadow_count, seen == hits));
                    end
            end
            MODE_TAKE:
            begin
                if (r.slot >= shadow_count)
                    step_results.push_back(make_result(STATUS_BAD_SLOT, r.slot, '0, '0,
                                                       shadow_count, 1'b1));
                else
                begin
                    taken_tag  = shadow_tags[r.slot];
                    taken_word = shadow_words[r.slot];
                    // close the gap, then clear the vacated top position
                    for (int i = r.slot; i + 1 < shadow_count; i++)
                    begin
                        shadow_tags[i]  = shadow_tags[i + 1];
                        shadow_words[i] = shadow_words[i + 1];
                    end
                    shadow_count = shadow_count - 1'b1;
                    shadow_tags[shadow_count]  = '0;
                    shadow_words[shadow_count] = '0;
                    step_results.push_back(make_result(STATUS_OK, r.slot, taken_tag,
                                                       taken_word, shadow_count, 1'b1));
                end
            end
            default:
                ;   // mode 3: no result, no state change
        endcase
    endfunction

    //------------------------------------------------------------------
    // Directed table builders
    //------------------------------------------------------------------
    function automatic table_req_t make_req(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t,
                                            logic [WORD_W-1:0] p, logic [IDX_W-1:0] s);
        table_req_t r;
        r.mode    = m;
        r.tag     = t;
        r.payload = p;
        r.slot    = s;
        return r;
    endfunction

    function automatic void add_predicted(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t,
                                          logic [WORD_W-1:0] p, logic [IDX_W-1:0] s);
        directed_row_t row;
        row.kind     = ROW_PREDICTED;
        row.req      = make_req(m, t, p, s);
        row.want     = make_result('0, '0, '0, '0, '0, 1'b0);
        row.capacity = '0;
        directed_rows.push_back(row);
    endfunction

    // Single-result rows whose outcome is obvious by inspection.
    function automatic void add_typed(logic [MODE_W-1:0] m, logic [TAG_W-1:0] t,
                                      logic [WORD_W-1:0] p, logic [IDX_W-1:0] s,
                                      logic [STATUS_W-1:0] st, logic [IDX_W-1:0] idx,
                                      logic [TAG_W-1:0] tg, logic [WORD_W-1:0] w,
                                      logic [CNT_W-1:0] cnt);
        directed_row_t row;
        row.kind     = ROW_TYPED;
        row.req      = make_req(m, t, p, s);
        row.want     = make_result(st, idx, tg, w, cnt, 1'b1);
        row.capacity = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_capacity(logic [CNT_W-1:0] v);
        directed_row_t row;
        row.kind     = ROW_CAPACITY;
        row.req      = make_req('0, '0, '0, '0);
        row.want     = make_result('0, '0, '0, '0, '0, 1'b0);
        row.capacity = v;
        directed_rows.push_back(row);
    endfunction

    //------------------------------------------------------------------
    // Random request generator
    //------------------------------------------------------------------
    function automatic table_req_t random_request(int insert_pct, int take_pct,
                                                  int pool_base, int pool_width);
        table_req_t r;
        int         roll;
        int         slot_hi;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.mode = MODE_UNUSED;
        else if (roll < 3 + insert_pct)
            r.mode = MODE_INSERT;
        else if (roll < 3 + insert_pct + take_pct)
            r.mode = MODE_TAKE;
        else
            r.mode = MODE_SCAN;
        // a narrow tag pool makes scans hit several entries
        if (pool_width == 0)
            r.tag = TAG_W'($urandom_range(0, 255));
        else
            r.tag = TAG_W'(pool_base + $urandom_range(0, pool_width - 1));
        if (r.mode == MODE_SCAN && shadow_count != 0 && $urandom_range(0, 1) == 1)
            r.tag = shadow_tags[$urandom_range(0, shadow_count - 1)];
        r.payload = $urandom;
        // mostly live slots plus the first dead one, sometimes anything
        slot_hi = (shadow_count < DEPTH) ? shadow_count : DEPTH - 1;
        if ($urandom_range(0, 4) == 0)
            r.slot = IDX_W'($urandom_range(0, DEPTH - 1));
        else
            r.slot = IDX_W'($urandom_range(0, slot_hi));
        return r;
    endfunction

    //------------------------------------------------------------------
    // Request driver with burst/gap pacing
    //------------------------------------------------------------------
    task automatic send_request(input table_req_t r, input bit typed,
                                input table_result_t want);
        int gap;
        in_valid <= 1'b1;
        mode     <= r.mode;
        tag      <= r.tag;
        payload  <= r.payload;
        slot     <= r.slot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // request taken at this edge
        predict_table_op(r);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[k])
                pending_results.push_back(step_results[k]);
        mode_seen[r.mode]++;
        if (r.mode == MODE_SCAN && step_results.size() > longest_scan)
            longest_scan = step_results.size();

        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        drain_and_settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_capacity = v;
        capacity_writes++;
    endtask

    //------------------------------------------------------------------
    // Result checker and receiver stall pattern
    //------------------------------------------------------------------
    function automatic int field_differs(string name, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin : result_check
        table_result_t oldest;
        int            bad;
        int            stall_style;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with nothing expected, status %0d index %0d",
                         $time, status, index_out);
            end
            else
            begin
                oldest = pending_results.pop_front();
                bad = 0;
                bad += field_differs("status", oldest.status, status);
                bad += field_differs("index_out", oldest.index, index_out);
                bad += field_differs("tag_out", oldest.tag, tag_out);
                bad += field_differs("payload_out", oldest.word, payload_out);
                bad += field_differs("entries_in_use", oldest.count, entries_in_use);
                bad += field_differs("last", oldest.last, last);
                if (bad != 0)
                    failures++;
                results_checked++;
                status_seen[status]++;
            end
        end
        // stall style rotates: none, light random, periodic, heavy random
        stall_style = (cycles / 256) % 4;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 40);
            2:       out_stall <= ((cycles % 7) < 3);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial
    begin
        table_req_t    r;
        table_result_t no_result;
        int            phase;
        int            profile;
        int            phase_len;
        int            insert_pct;
        int            take_pct;
        int            pool_base;
        int            pool_width;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        mode        <= MODE_INSERT;
        tag         <= '0;
        payload     <= '0;
        slot        <= '0;
        foreach (shadow_tags[i])
        begin
            shadow_tags[i]  = '0;
            shadow_words[i] = '0;
        end
        shadow_count    = '0;
        shadow_capacity = CNT_W'(32);
        no_result       = make_result('0, '0, '0, '0, '0, 1'b0);

        // Directed part; starts from reset with capacity 32
        add_typed(MODE_TAKE, 8'h00, 32'h0000_0000, 5'd0,          // take on empty
                  STATUS_BAD_SLOT, 5'd0, 8'h00, 32'h0000_0000, 6'd0);
        add_typed(MODE_SCAN, 8'h00, 32'h0000_0000, 5'd0,          // scan on empty
                  STATUS_NO_MATCH, 5'd0, 8'h00, 32'h0000_0000, 6'd0);
        add_typed(MODE_INSERT, 8'hFF, 32'hFFFF_FFFF, 5'd31,
                  STATUS_OK, 5'd0, 8'h00, 32'h0000_0000, 6'd1);
        add_typed(MODE_INSERT, 8'h00, 32'h0000_0000, 5'd0,
                  STATUS_OK, 5'd0, 8'h00, 32'h0000_0000, 6'd2);
        add_predicted(MODE_INSERT, 8'hFF, 32'hA5A5_5A5A, 5'd10);
        add_predicted(MODE_INSERT, 8'h3C, 32'h0000_0001, 5'd21);
        add_predicted(MODE_SCAN, 8'hFF, 32'h0000_0000, 5'd0);     // two matches
        add_typed(MODE_SCAN, 8'h77, 32'h0000_0000, 5'd0,
                  STATUS_NO_MATCH, 5'd0, 8'h00, 32'h0000_0000, 6'd4);
        add_typed(MODE_TAKE, 8'h00, 32'h0000_0000, 5'd31,         // far past the count
                  STATUS_BAD_SLOT, 5'd31, 8'h00, 32'h0000_0000, 6'd4);
        add_typed(MODE_TAKE, 8'h00, 32'h0000_0000, 5'd4,          // first dead slot
                  STATUS_BAD_SLOT, 5'd4, 8'h00, 32'h0000_0000, 6'd4);
        add_typed(MODE_TAKE, 8'h00, 32'h0000_0000, 5'd0,          // head, everything shifts
                  STATUS_OK, 5'd0, 8'hFF, 32'hFFFF_FFFF, 6'd3);
        add_predicted(MODE_SCAN, 8'hFF, 32'h0000_0000, 5'd0);
        add_predicted(MODE_UNUSED, 8'hAA, 32'h5555_AAAA, 5'd21);  // dropped, no result
        add_predicted(MODE_TAKE, 8'h00, 32'h0000_0000, 5'd2);     // tail, nothing shifts
        add_predicted(MODE_INSERT, 8'h00, 32'h8000_0000, 5'd0);
        add_predicted(MODE_SCAN, 8'h00, 32'h0000_0000, 5'd0);
        add_capacity(6'd3);
        add_typed(MODE_INSERT, 8'h12, 32'h1234_5678, 5'd0,        // count at capacity
                  STATUS_FULL, 5'd0, 8'h00, 32'h0000_0000, 6'd3);
        add_capacity(6'd0);
        add_typed(MODE_INSERT, 8'h00, 32'h0000_0000, 5'd0,        // zero: always full
                  STATUS_FULL, 5'd0, 8'h00, 32'h0000_0000, 6'd3);
        add_capacity(6'd63);
        add_typed(MODE_INSERT, 8'h5A, 32'h0000_FFFF, 5'd0,        // above depth acts as 32
                  STATUS_OK, 5'd0, 8'h00, 32'h0000_0000, 6'd4);
        add_predicted(MODE_TAKE, 8'h00, 32'h0000_0000, 5'd1);     // middle take
        add_predicted(MODE_SCAN, 8'h5A, 32'h0000_0000, 5'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CAPACITY)
                write_capacity(directed_rows[i].capacity);
            else
                send_request(directed_rows[i].req, directed_rows[i].kind == ROW_TYPED,
                             directed_rows[i].want);
        end

        // Random phases; the capacity changes only between phases, table idle.
        // Phase 0 inserts mostly one tag, so scans on it match every such stored entry.
        phase = 0;
        while (random_sent < RANDOM_REQUESTS)
        begin
            profile = phase % 4;
            case (profile)
                0:       begin insert_pct = 85; take_pct = 5;  pool_width = 1; end
                1:       begin insert_pct = 10; take_pct = 75; pool_width = 4; end
                2:       begin insert_pct = 40; take_pct = 30; pool_width = 0; end
                default: begin insert_pct = 65; take_pct = 15; pool_width = 3; end
            endcase
            pool_base = $urandom_range(0, 255);
            phase_len = $urandom_range(30, 55);
            write_capacity((phase < 8) ? CNT_W'(capacity_plan[phase])
                                       : CNT_W'($urandom_range(1, 32)));
            for (int n = 0; n < phase_len && random_sent < RANDOM_REQUESTS; n++)
            begin
                r = random_request(insert_pct, take_pct, pool_base, pool_width);
                send_request(r, 1'b0, no_result);
                if (r.mode != MODE_UNUSED)
                    random_sent++;
            end
            phase++;
        end

        drain_and_settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d scans, %0d takes, %0d dropped requests; %0d capacity writes.",
                 mode_seen[MODE_INSERT], mode_seen[MODE_SCAN], mode_seen[MODE_TAKE],
                 mode_seen[MODE_UNUSED], capacity_writes);
        $display("Checked %0d results (%0d full, %0d bad slot, %0d no match), longest scan %0d.",
                 results_checked, status_seen[STATUS_FULL], status_seen[STATUS_BAD_SLOT],
                 status_seen[STATUS_NO_MATCH], longest_scan);
        if (failures == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
